### hw/rtl/spq_pkg.sv
package spq_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned EntryW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REL_LT = 2'd0,
    REL_LE = 2'd1,
    REL_GT = 2'd2,
    REL_GE = 2'd3
  } rel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_POP,
    S_READ,
    S_OUT
  } state_e;

  function automatic logic rel_holds(input logic [1:0] mode, input logic signed [15:0] fresh,
                                     input logic signed [15:0] stored);
    logic r;
    unique case (rel_e'(mode))
      REL_LT: r = fresh < stored;
      REL_LE: r = fresh <= stored;
      REL_GT: r = fresh > stored;
      REL_GE: r = fresh >= stored;
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

### hw/rtl/sorted_priority_queue.sv
// Sorted-list priority queue, capacity 64 (value, priority) pairs.
// Input channel (in_valid_i/in_ready_o): cmd_i, item_value_i, priority_req_i,
// rank_i. Commands: insert, pop head, read at rank (0 reads as 1).
// Output channel (out_valid_o/out_ready_i): out_value_o, out_priority_o,
// status_o; one result per item, in order.
// Config channel (cfg_valid_i/cfg_ready_o) writes relation_mode (reset 1):
// 0 less, 1 less-equal, 2 greater, 3 greater-equal, new versus stored.
// The list sits in one single-port-read RAM; each item is worked one at a
// time by a sequencer. Insert scans from the head, one RAM read a cycle,
// for the first stored entry the relation holds for, moves the entries
// from there to the tail up one slot, each move a read then a write, and
// writes the new item there; pop captures the head and moves the rest down
// one slot. The result waits on out_valid_o in an output register, so the
// next item is worked meanwhile; with the receiver stalled, a second
// finished result holds the sequencer and no new item is taken. Reset
// empties the queue at once (no clearing pass) and returns relation_mode
// to 1.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] item_value_i,
  input  logic signed [15:0] priority_req_i,
  input  logic [6:0]  rank_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_value_o,
  output logic signed [15:0] out_priority_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);
  state_e state_q, state_d;
  logic [1:0] mode_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [15:0] val_q, val_d;
  logic signed [15:0] pri_q, pri_d;
  logic [15:0] ov_q, ov_d;
  logic signed [15:0] op_q, op_d;
  logic [1:0] st_q, st_d;
  logic phase_q, phase_d;

  logic res_valid_q;
  logic [15:0] res_value_q;
  logic signed [15:0] res_prio_q;
  logic [1:0] res_status_q;
  logic res_load;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  spq_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [CntW-1:0] k;
  assign k = (rank_i == 7'd0) ? CntW'(1) : CntW'(rank_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_load    = (state_q == S_OUT) && (!res_valid_q || out_ready_i);
  assign out_valid_o = res_valid_q;
  assign out_value_o = res_value_q;
  assign out_priority_o = res_prio_q;
  assign status_o = res_status_q;

  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; pos_d = pos_q;
    val_d = val_q; pri_d = pri_q; ov_d = ov_q; op_d = op_q; st_d = st_q;
    phase_d = phase_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ov_d = '0; op_d = '0; st_d = ST_OK; val_d = item_value_i;
          pri_d = priority_req_i; idx_d = '0; phase_d = 1'b0;
          unique case (cmd_e'(cmd_i))
            CMD_INSERT: begin
              if (count_q >= CntW'(Capacity)) begin
                st_d = ST_FULL; state_d = S_OUT;
              end else if (count_q == '0) begin
                pos_d = '0; idx_d = '0; state_d = S_SHIFT;
              end else begin
                raddr = '0; state_d = S_SCAN;
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY; state_d = S_OUT;
              end else begin
                raddr = '0; idx_d = '0; state_d = S_POP;
              end
            end
            CMD_READ: begin
              if (k > count_q || k > CntW'(Capacity)) begin
                st_d = ST_EMPTY; state_d = S_OUT;
              end else begin
                raddr = AddrW'(k - CntW'(1)); state_d = S_READ;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_READ: begin
        ov_d = rdata[31:16]; op_d = rdata[15:0]; state_d = S_OUT;
      end
      S_SCAN: begin
        // rdata holds entry idx_q
        if (rel_holds(mode_q, pri_q, rdata[15:0])) begin
          pos_d = idx_q; idx_d = count_q; state_d = S_SHIFT; phase_d = 1'b0;
        end else if (idx_q + CntW'(1) == count_q) begin
          pos_d = count_q; idx_d = count_q; state_d = S_SHIFT; phase_d = 1'b0;
        end else begin
          idx_d = idx_q + CntW'(1); raddr = AddrW'(idx_d);
        end
      end
      S_SHIFT: begin
        // move entry idx-1 to idx, down to pos, then write new item
        if (idx_q == pos_q) begin
          we = 1'b1; waddr = AddrW'(pos_q); wdata = {val_q, pri_q};
          count_d = count_q + CntW'(1); state_d = S_OUT;
        end else if (!phase_q) begin
          raddr = AddrW'(idx_q - CntW'(1)); phase_d = 1'b1;
        end else begin
          we = 1'b1; waddr = AddrW'(idx_q); wdata = rdata;
          idx_d = idx_q - CntW'(1); phase_d = 1'b0;
        end
      end
      S_POP: begin
        // phase 0: rdata is entry idx; capture head or write to idx-1
        if (!phase_q) begin
          if (idx_q == '0) begin
            ov_d = rdata[31:16]; op_d = rdata[15:0];
          end else begin
            we = 1'b1; waddr = AddrW'(idx_q - CntW'(1)); wdata = rdata;
          end
          if (idx_q + CntW'(1) == count_q) begin
            count_d = count_q - CntW'(1); state_d = S_OUT;
          end else begin
            idx_d = idx_q + CntW'(1); phase_d = 1'b1;
          end
        end else begin
          raddr = AddrW'(idx_q); phase_d = 1'b0;
        end
      end
      S_OUT: begin
        // hand the result over once the output register is free
        if (!res_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= REL_LE;
      count_q <= '0;
      phase_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; pos_q <= pos_d; val_q <= val_d; pri_q <= pri_d;
    ov_q <= ov_d; op_q <= op_d; st_q <= st_d;
    if (res_load) begin
      res_value_q <= ov_q; res_prio_q <= op_q; res_status_q <= st_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Capacity))
    else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(status_o))
    else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && st_q == ST_FULL) |-> count_q == CntW'(Capacity))
    else $error("bad full status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_value_o) && $stable(out_priority_o))
    else $error("result changed while stalled");
endmodule

### hw/rtl/spq_ram.sv
module spq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
